/* hdl/sht_pkg.sv */
// Shared types and constants of the string key hash table.
package sht_pkg;

    localparam logic [31:0] HASH_OFFSET = 32'd2166136261;
    localparam logic [31:0] HASH_PRIME  = 32'd16777619;
    localparam logic [7:0]  TOMB_BYTE   = 8'h7F;

    localparam int FUNC_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int CFG_W    = 6;

    localparam logic [FUNC_W-1:0] FN_SET    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;
    localparam logic [FUNC_W-1:0] FN_SPARE  = 2'd3;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = 6'd48;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_LIVE  = 2'd1,
        TAG_TOMB  = 2'd2
    } tag_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_DELETED   = 3'd4,
        ST_FULL      = 3'd5,
        ST_BAD       = 3'd6
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_MOD,
        S_REM,
        S_PRB,
        S_CHK,
        S_CMPRD,
        S_CMPCHK,
        S_ACT,
        S_COPYRD,
        S_COPYWR,
        S_DONE
    } state_t;

endpackage

/* hdl/sht_if.sv */
// Channel interfaces of the string key hash table: request, result and configuration.
interface sht_req_if;
    logic                          valid;
    logic                          ready;
    logic [sht_pkg::FUNC_W-1:0]    func;
    logic [sht_pkg::BYTE_W-1:0]    name_byte;
    logic                          last_byte;
    logic [sht_pkg::VALUE_W-1:0]   value_in;
    logic                          const_in;
    modport source (output valid, func, name_byte, last_byte, value_in, const_in,
                    input ready);
    modport sink (input valid, func, name_byte, last_byte, value_in, const_in,
                  output ready);
endinterface

interface sht_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sht_pkg::STATUS_W-1:0]  status;
    logic [sht_pkg::VALUE_W-1:0]   value_out;
    logic                          const_out;
    logic [sht_pkg::SLOT_W-1:0]    slot_out;
    logic [sht_pkg::COUNT_W-1:0]   entries_now;
    modport source (output valid, status, value_out, const_out, slot_out, entries_now,
                    input ready);
    modport sink (input valid, status, value_out, const_out, slot_out, entries_now,
                  output ready);
endinterface

interface sht_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [sht_pkg::CFG_W-1:0]   data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* hdl/string_key_hash_table.sv */
// Top level of the string key hash table: byte intake, hashing, probing and slot update.
//
// A name enters on req one byte per item, first byte first, with last_byte set on the
// final byte. Each byte is taken while a 32-bit FNV-1a hash runs over it.
// The item carrying last_byte also carries func, value_in and const_in, and it starts
// the operation: set, lookup or delete by linear probing from slot hash mod CAPACITY.
// Exactly one result item leaves on rsp for each last byte; other bytes give none.
// The cfg channel writes the load limit max_entries; it is always ready.
//
// Cost: a byte is taken only while no operation runs. An operation visits the probed
// slots one by one, compares the name byte by byte with each live slot of equal name
// length that it meets, and copies a newly inserted name byte by byte. The cost is set
// by the single read port of the slot memory, which is visited one slot at a time, and
// by the byte-wide name memory. Where CAPACITY is not a power of two, a reciprocal
// multiplication and a subtraction find the home slot.
// The next name's bytes are taken while a finished result still waits on rsp; only the
// start of a further result waits for the output register to empty.
// After reset the block marks every slot empty, one slot after another, and takes no
// request item meanwhile (configuration writes are taken as usual).
module string_key_hash_table #(
    parameter int CAPACITY    = 64,
    parameter int MAX_NAME    = 32,
    parameter int VALUE_WIDTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    sht_req_if.sink    req,
    sht_rsp_if.source  rsp,
    sht_cfg_if.sink    cfg
);

    localparam int  AW         = $clog2(CAPACITY);
    localparam int  RW         = $clog2(CAPACITY + 1);
    localparam int  NW         = $clog2(MAX_NAME);
    localparam int  LW         = $clog2(MAX_NAME + 1);
    localparam int  NAME_DEPTH = (CAPACITY + 1) << NW;
    localparam bit  POW2       = (CAPACITY & (CAPACITY - 1)) == 0;
    localparam logic [RW-1:0] SCRATCH_ROW = RW'(CAPACITY);
    // Rounded-up reciprocal of CAPACITY; exact quotient for every 32-bit hash.
    localparam logic [63:0] RECIP = ((64'd1 << (32 + AW)) + 64'(CAPACITY) - 64'd1)
                                    / 64'(CAPACITY);

    typedef struct packed {
        sht_pkg::tag_t            tag;
        logic [LW-1:0]            len;
        logic                     cst;
        logic [VALUE_WIDTH-1:0]   val;
    } rec_t;

    // Slot records and name bytes. The last name row holds the name being received.
    rec_t       slot_mem [CAPACITY];
    logic [7:0] name_mem [NAME_DEPTH];

    sht_pkg::state_t state_reg, state_next;

    logic [31:0]            hash_reg, hash_next;
    logic [LW-1:0]          len_reg, len_next;
    logic [7:0]             first_reg, first_next;
    logic [1:0]             func_reg, func_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic                   cst_reg, cst_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic [AW-1:0]          home_reg, home_next;
    logic [RW-1:0]          cnt_reg, cnt_next;
    logic [NW-1:0]          k_reg, k_next;
    logic                   tomb_reg, tomb_next;
    logic                   matched_reg, matched_next;
    logic [AW-1:0]          target_reg, target_next;
    logic [VALUE_WIDTH-1:0] mval_reg, mval_next;
    logic                   mcst_reg, mcst_next;
    logic [31:0]            quot_reg, quot_next;
    logic [RW-1:0]          live_reg, live_next;
    logic [5:0]             max_reg;
    logic [AW-1:0]          clr_reg, clr_next;

    sht_pkg::status_t       res_status_reg, res_status_next;
    logic [VALUE_WIDTH-1:0] res_val_reg, res_val_next;
    logic                   res_cst_reg, res_cst_next;
    logic [AW-1:0]          res_slot_reg, res_slot_next;

    logic                   out_valid_reg, out_valid_next;
    sht_pkg::status_t       out_status_reg;
    logic [VALUE_WIDTH-1:0] out_val_reg;
    logic                   out_cst_reg;
    logic [AW-1:0]          out_slot_reg;
    logic [RW-1:0]          out_live_reg;

    logic                   slot_we;
    logic [AW-1:0]          slot_wa;
    rec_t                   slot_wd;
    rec_t                   slot_rd_reg;

    logic                   name_we;
    logic [RW+NW-1:0]       name_wa;
    logic [7:0]             name_wd;
    logic [RW+NW-1:0]       name_raa, name_rab;
    logic [7:0]             name_rda_reg, name_rdb_reg;

    logic                   req_take;
    logic                   out_load;
    logic                   bad_name;
    logic                   cnt_last;
    logic                   k_last;
    logic                   bytes_differ;
    logic [AW-1:0]          idx_wrap;
    logic [64:0]            recip_prod;
    logic [31:0]            rem_full;
    logic                   is_insert;

    assign req.ready    = (state_reg == sht_pkg::S_IDLE);
    assign req_take     = req.valid && req.ready;
    assign cfg.ready    = 1'b1;
    assign out_load     = (state_reg == sht_pkg::S_DONE) && (!out_valid_reg || rsp.ready);

    assign bad_name     = (32'(len_reg) >= MAX_NAME) || (first_reg == sht_pkg::TOMB_BYTE);
    assign cnt_last     = (32'(cnt_reg) + 32'd1 == CAPACITY);
    assign k_last       = (32'(k_reg) + 32'd1 == 32'(len_reg));
    assign bytes_differ = (name_rda_reg != name_rdb_reg);
    assign idx_wrap     = (32'(idx_reg) == CAPACITY - 1) ? '0 : idx_reg + 1'b1;

    // Home slot for a capacity that is not a power of two: the quotient comes from a
    // multiplication by the reciprocal in S_MOD, and the remainder from it in the next state.
    assign recip_prod = {33'd0, hash_reg} * {32'd0, RECIP[32:0]};
    assign rem_full   = hash_reg - quot_reg * 32'(CAPACITY);

    // A set of a new name inserts only with room under the limit and a free slot found.
    assign is_insert = (func_reg == sht_pkg::FN_SET) && !matched_reg && tomb_reg
                       && (32'(live_reg) < 32'(max_reg));

    assign name_raa = {RW'(idx_reg), k_reg};
    assign name_rab = {SCRATCH_ROW, k_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sht_pkg::S_CLEAR:
            begin
                if (32'(clr_reg) == CAPACITY - 1)
                    state_next = sht_pkg::S_IDLE;
            end
            sht_pkg::S_IDLE:
            begin
                if (req_take && req.last_byte)
                    state_next = sht_pkg::S_START;
            end
            sht_pkg::S_START:
            begin
                if (bad_name)
                    state_next = sht_pkg::S_DONE;
                else if (POW2)
                    state_next = sht_pkg::S_PRB;
                else
                    state_next = sht_pkg::S_MOD;
            end
            sht_pkg::S_MOD:
                state_next = sht_pkg::S_REM;
            sht_pkg::S_REM:
                state_next = sht_pkg::S_PRB;
            sht_pkg::S_PRB:
                state_next = sht_pkg::S_CHK;
            sht_pkg::S_CHK:
            begin
                if (slot_rd_reg.tag == sht_pkg::TAG_EMPTY)
                    state_next = sht_pkg::S_ACT;
                else if (slot_rd_reg.tag == sht_pkg::TAG_LIVE && slot_rd_reg.len == len_reg)
                    state_next = sht_pkg::S_CMPRD;
                else
                    state_next = cnt_last ? sht_pkg::S_ACT : sht_pkg::S_PRB;
            end
            sht_pkg::S_CMPRD:
                state_next = sht_pkg::S_CMPCHK;
            sht_pkg::S_CMPCHK:
            begin
                if (bytes_differ)
                    state_next = cnt_last ? sht_pkg::S_ACT : sht_pkg::S_PRB;
                else if (k_last)
                    state_next = sht_pkg::S_ACT;
                else
                    state_next = sht_pkg::S_CMPRD;
            end
            sht_pkg::S_ACT:
                state_next = is_insert ? sht_pkg::S_COPYRD : sht_pkg::S_DONE;
            sht_pkg::S_COPYRD:
                state_next = sht_pkg::S_COPYWR;
            sht_pkg::S_COPYWR:
                state_next = k_last ? sht_pkg::S_DONE : sht_pkg::S_COPYRD;
            sht_pkg::S_DONE:
            begin
                if (out_load)
                    state_next = sht_pkg::S_IDLE;
            end
            default:
                state_next = sht_pkg::S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        hash_next       = hash_reg;
        len_next        = len_reg;
        first_next      = first_reg;
        func_next       = func_reg;
        val_next        = val_reg;
        cst_next        = cst_reg;
        idx_next        = idx_reg;
        home_next       = home_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        tomb_next       = tomb_reg;
        matched_next    = matched_reg;
        target_next     = target_reg;
        mval_next       = mval_reg;
        mcst_next       = mcst_reg;
        quot_next       = quot_reg;
        live_next       = live_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_val_next    = res_val_reg;
        res_cst_next    = res_cst_reg;
        res_slot_next   = res_slot_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;

        slot_we = 1'b0;
        slot_wa = target_reg;
        slot_wd = '{tag: sht_pkg::TAG_LIVE, len: len_reg, cst: cst_reg, val: val_reg};
        name_we = 1'b0;
        name_wa = {SCRATCH_ROW, len_reg[NW-1:0]};
        name_wd = req.name_byte;

        case (state_reg)
            sht_pkg::S_CLEAR:
            begin
                slot_we  = 1'b1;
                slot_wa  = clr_reg;
                slot_wd  = '{tag: sht_pkg::TAG_EMPTY, len: '0, cst: 1'b0, val: '0};
                clr_next = clr_reg + 1'b1;
            end
            sht_pkg::S_IDLE:
            begin
                if (req_take)
                begin
                    hash_next = (hash_reg ^ {24'd0, req.name_byte}) * sht_pkg::HASH_PRIME;
                    if (len_reg == '0)
                        first_next = req.name_byte;
                    if (req.name_byte == 8'd0)
                        len_next = LW'(MAX_NAME);
                    else if (32'(len_reg) < MAX_NAME)
                        len_next = len_reg + 1'b1;
                    // Byte zero never lands in storage; a too-long name is marked by length.
                    name_we = (req.name_byte != 8'd0) && (32'(len_reg) < MAX_NAME - 1);
                    if (req.last_byte)
                    begin
                        func_next = req.func;
                        val_next  = req.value_in[VALUE_WIDTH-1:0];
                        cst_next  = req.const_in;
                    end
                end
            end
            sht_pkg::S_START:
            begin
                cnt_next     = '0;
                tomb_next    = 1'b0;
                matched_next = 1'b0;
                idx_next     = hash_reg[AW-1:0];
                home_next    = hash_reg[AW-1:0];
                res_val_next = '0;
                res_cst_next = 1'b0;
                if (bad_name)
                begin
                    res_status_next = sht_pkg::ST_BAD;
                    res_slot_next   = '0;
                end
            end
            sht_pkg::S_MOD:
            begin
                quot_next = 32'(recip_prod >> (32 + AW));
            end
            sht_pkg::S_REM:
            begin
                idx_next  = rem_full[AW-1:0];
                home_next = rem_full[AW-1:0];
            end
            sht_pkg::S_CHK:
            begin
                k_next = '0;
                if (slot_rd_reg.tag != sht_pkg::TAG_LIVE && !tomb_reg)
                begin
                    tomb_next   = 1'b1;
                    target_next = idx_reg;
                end
                if (slot_rd_reg.tag == sht_pkg::TAG_LIVE)
                begin
                    mval_next = slot_rd_reg.val;
                    mcst_next = slot_rd_reg.cst;
                end
                if (slot_rd_reg.tag != sht_pkg::TAG_EMPTY
                    && !(slot_rd_reg.tag == sht_pkg::TAG_LIVE && slot_rd_reg.len == len_reg))
                begin
                    cnt_next = cnt_reg + 1'b1;
                    idx_next = idx_wrap;
                end
            end
            sht_pkg::S_CMPCHK:
            begin
                if (bytes_differ)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    idx_next = idx_wrap;
                end
                else if (k_last)
                begin
                    matched_next = 1'b1;
                    target_next  = idx_reg;
                end
                else
                    k_next = k_reg + 1'b1;
            end
            sht_pkg::S_ACT:
            begin
                k_next        = '0;
                res_slot_next = target_reg;
                if (func_reg == sht_pkg::FN_SET)
                begin
                    if (matched_reg)
                    begin
                        slot_we         = 1'b1;
                        res_status_next = sht_pkg::ST_UPDATED;
                    end
                    else if (is_insert)
                    begin
                        slot_we         = 1'b1;
                        live_next       = live_reg + 1'b1;
                        res_status_next = sht_pkg::ST_INSERTED;
                    end
                    else
                    begin
                        res_status_next = sht_pkg::ST_FULL;
                        res_slot_next   = home_reg;
                    end
                end
                else if (live_reg == '0 || !matched_reg)
                begin
                    res_status_next = sht_pkg::ST_NOT_FOUND;
                    res_slot_next   = home_reg;
                end
                else if (func_reg == sht_pkg::FN_DELETE)
                begin
                    slot_we         = 1'b1;
                    slot_wd         = '{tag: sht_pkg::TAG_TOMB, len: len_reg,
                                        cst: mcst_reg, val: mval_reg};
                    live_next       = live_reg - 1'b1;
                    res_status_next = sht_pkg::ST_DELETED;
                end
                else
                begin
                    res_status_next = sht_pkg::ST_FOUND;
                    res_val_next    = mval_reg;
                    res_cst_next    = mcst_reg;
                end
            end
            sht_pkg::S_COPYWR:
            begin
                name_we = 1'b1;
                name_wa = {RW'(target_reg), k_reg};
                name_wd = name_rdb_reg;
                k_next  = k_reg + 1'b1;
            end
            sht_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    hash_next      = sht_pkg::HASH_OFFSET;
                    len_next       = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sht_pkg::S_CLEAR;
            hash_reg      <= sht_pkg::HASH_OFFSET;
            len_reg       <= '0;
            live_reg      <= '0;
            max_reg       <= sht_pkg::MAX_ENTRIES_RESET;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hash_reg      <= hash_next;
            len_reg       <= len_next;
            live_reg      <= live_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
                max_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg      <= first_next;
        func_reg       <= func_next;
        val_reg        <= val_next;
        cst_reg        <= cst_next;
        idx_reg        <= idx_next;
        home_reg       <= home_next;
        cnt_reg        <= cnt_next;
        k_reg          <= k_next;
        tomb_reg       <= tomb_next;
        matched_reg    <= matched_next;
        target_reg     <= target_next;
        mval_reg       <= mval_next;
        mcst_reg       <= mcst_next;
        quot_reg       <= quot_next;
        res_status_reg <= res_status_next;
        res_val_reg    <= res_val_next;
        res_cst_reg    <= res_cst_next;
        res_slot_reg   <= res_slot_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_val_reg    <= res_val_reg;
            out_cst_reg    <= res_cst_reg;
            out_slot_reg   <= res_slot_reg;
            out_live_reg   <= live_reg;
        end
    end

    // Slot record memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_wa] <= slot_wd;
        slot_rd_reg <= slot_mem[idx_reg];
    end

    // Name byte memory: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (name_we)
            name_mem[name_wa] <= name_wd;
        name_rda_reg <= name_mem[name_raa];
        name_rdb_reg <= name_mem[name_rab];
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.value_out   = sht_pkg::VALUE_W'(out_val_reg);
    assign rsp.const_out   = out_cst_reg;
    assign rsp.slot_out    = sht_pkg::SLOT_W'(out_slot_reg);
    assign rsp.entries_now = sht_pkg::COUNT_W'(out_live_reg);

`ifndef ASSERT_OFF
    // The live count can never pass the number of slots.
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(live_reg) <= CAPACITY)
        else $error("live entry count exceeds capacity");

    // While the slots are being cleared no request item is taken.
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sht_pkg::S_CLEAR) |-> !req.ready)
        else $error("request taken during clearing pass");

    // A probe never visits more slots than the table holds.
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sht_pkg::S_PRB || state_reg == sht_pkg::S_CHK)
        |-> 32'(cnt_reg) < CAPACITY)
        else $error("probe ran past capacity");
`endif

endmodule

/* sim/sht_checker.sv */
// Checker for the string key hash table: predicts each result item and compares it.
module sht_checker (
    input  logic   clk,
    input  logic   rst_n,
    sht_req_if     req,
    sht_rsp_if     rsp,
    sht_cfg_if     cfg,
    output int     fail_count,
    output int     awaited
);

    localparam int SLOTS   = 64;
    localparam int NAME_LEN = 32;

    typedef struct {
        sht_pkg::status_t              status;
        logic [sht_pkg::VALUE_W-1:0]   value;
        logic                          cflag;
        logic [sht_pkg::SLOT_W-1:0]    slot;
        logic [sht_pkg::COUNT_W-1:0]   count;
    } outcome_t;

    sht_pkg::tag_t               tags [SLOTS];
    logic [7:0]                  slot_names [SLOTS][NAME_LEN];
    int                          slot_lens [SLOTS];
    logic [sht_pkg::VALUE_W-1:0] slot_vals [SLOTS];
    logic                        slot_consts [SLOTS];
    logic [7:0]                  pend [NAME_LEN];
    int                          pend_len;
    logic [31:0]                 hash;
    int                          live;
    int                          limit;
    outcome_t                    expected_outcomes [$];

    assign awaited = expected_outcomes.size();

    function automatic bit same_name(int s);
        if (slot_lens[s] != pend_len)
            return 0;
        for (int k = 0; k < pend_len; k++)
            if (slot_names[s][k] != pend[k])
                return 0;
        return 1;
    endfunction

    // Applies one accepted byte to the table image; returns 1 with an outcome on a last byte.
    function automatic bit table_step(input logic [1:0] fn, input logic [7:0] b,
                                      input logic last, input logic [63:0] val,
                                      input logic cf, output outcome_t o);
        int home;
        int idx;
        int target;
        bit matched;
        bit have_free;
        hash = (hash ^ {24'd0, b}) * sht_pkg::HASH_PRIME;
        if (b == 8'd0)
            pend_len = NAME_LEN;
        else if (pend_len < NAME_LEN)
        begin
            if (pend_len < NAME_LEN - 1)
                pend[pend_len] = b;
            pend_len++;
        end
        if (!last)
            return 0;
        o = '{sht_pkg::ST_BAD, '0, 1'b0, '0, '0};
        if (!(pend_len >= NAME_LEN || pend[0] == sht_pkg::TOMB_BYTE))
        begin
            home = int'(hash[5:0]);
            idx = home;
            target = 0;
            matched = 0;
            have_free = 0;
            for (int k = 0; k < SLOTS; k++)
            begin
                if (tags[idx] == sht_pkg::TAG_EMPTY)
                begin
                    if (!have_free)
                    begin
                        target = idx;
                        have_free = 1;
                    end
                    break;
                end
                if (tags[idx] == sht_pkg::TAG_TOMB)
                begin
                    if (!have_free)
                    begin
                        target = idx;
                        have_free = 1;
                    end
                end
                else if (same_name(idx))
                begin
                    target = idx;
                    matched = 1;
                    break;
                end
                idx = (idx + 1) % SLOTS;
            end
            if (fn == sht_pkg::FN_SET)
            begin
                if (matched)
                begin
                    slot_vals[target] = val;
                    slot_consts[target] = cf;
                    o.status = sht_pkg::ST_UPDATED;
                    o.slot = target[5:0];
                end
                else if (live >= limit || !have_free)
                begin
                    o.status = sht_pkg::ST_FULL;
                    o.slot = home[5:0];
                end
                else
                begin
                    tags[target] = sht_pkg::TAG_LIVE;
                    for (int k = 0; k < pend_len; k++)
                        slot_names[target][k] = pend[k];
                    slot_lens[target] = pend_len;
                    slot_vals[target] = val;
                    slot_consts[target] = cf;
                    live++;
                    o.status = sht_pkg::ST_INSERTED;
                    o.slot = target[5:0];
                end
            end
            else if (live == 0 || !matched)
            begin
                o.status = sht_pkg::ST_NOT_FOUND;
                o.slot = home[5:0];
            end
            else if (fn == sht_pkg::FN_DELETE)
            begin
                tags[target] = sht_pkg::TAG_TOMB;
                live--;
                o.status = sht_pkg::ST_DELETED;
                o.slot = target[5:0];
            end
            else
            begin
                o.status = sht_pkg::ST_FOUND;
                o.value = slot_vals[target];
                o.cflag = slot_consts[target];
                o.slot = target[5:0];
            end
        end
        o.count = live[sht_pkg::COUNT_W-1:0];
        pend_len = 0;
        hash = sht_pkg::HASH_OFFSET;
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t o;
        outcome_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
                tags[s] = sht_pkg::TAG_EMPTY;
            pend_len = 0;
            hash = sht_pkg::HASH_OFFSET;
            live = 0;
            limit = int'(sht_pkg::MAX_ENTRIES_RESET);
            fail_count = 0;
            expected_outcomes.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                limit = int'(cfg.data);
            if (req.valid && req.ready)
                if (table_step(req.func, req.name_byte, req.last_byte, req.value_in,
                               req.const_in, o))
                    expected_outcomes.push_back(o);
            if (rsp.valid && rsp.ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result item: status %0d slot %0d",
                                 rsp.status, rsp.slot_out);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (rsp.status !== want.status || rsp.value_out !== want.value ||
                        rsp.const_out !== want.cflag || rsp.slot_out !== want.slot ||
                        rsp.entries_now !== want.count)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: expected st %0d val %h c %0d slot %0d n %0d,",
                                      " got st %0d val %h c %0d slot %0d n %0d"},
                                     want.status, want.value, want.cflag, want.slot,
                                     want.count, rsp.status, rsp.value_out, rsp.const_out,
                                     rsp.slot_out, rsp.entries_now);
                    end
                end
            end
        end
    end

endmodule

/* sim/testbench.sv */
// Top of the string key hash table testbench: stimulus, idling and the verdict.
module testbench;

    localparam int POOL = 96;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sht_req_if req ();
    sht_rsp_if rsp ();
    sht_cfg_if cfg ();

    int fail_count;
    int awaited;

    // Idling odds in percent for the sender and the receiver.
    int send_gap = 0;
    int recv_gap = 0;
    // A request for a long receiver hold; the receiver process takes it over.
    int hold_request = 0;

    // Name pool. The first few entries are fixed special names; the rest are random.
    logic [7:0] pool_bytes [POOL][40];
    int         pool_len [POOL];

    always #5 clk = ~clk;

    string_key_hash_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    sht_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .cfg        (cfg),
        .fail_count (fail_count),
        .awaited    (awaited)
    );

    // The receiver. Its own counter runs down a long hold, during which the sender keeps
    // offering items so that the block fills up and pushes back on its input.
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready = 1'b0;
            end
            else
                rsp.ready = ($urandom_range(99) >= recv_gap);
        end
    end

    // Offers one item and returns at the falling edge after it has been taken.
    task automatic send_item(input logic [1:0] fn, input logic [7:0] b, input logic last,
                             input logic [63:0] val, input logic cf);
        while ($urandom_range(99) < send_gap)
        begin
            req.valid = 1'b0;
            @(negedge clk);
        end
        req.valid = 1'b1;
        req.func = fn;
        req.name_byte = b;
        req.last_byte = last;
        req.value_in = val;
        req.const_in = cf;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Sends a whole name from the pool. The bytes before the last one carry random
    // operation fields, which the block must ignore.
    task automatic send_name(input int n, input logic [1:0] fn, input logic [63:0] val,
                             input logic cf);
        for (int k = 0; k < pool_len[n]; k++)
            if (k == pool_len[n] - 1)
                send_item(fn, pool_bytes[n][k], 1'b1, val, cf);
            else
                send_item(2'($urandom), pool_bytes[n][k], 1'b0,
                          {$urandom, $urandom}, 1'($urandom));
        req.valid = 1'b0;
    endtask

    task automatic write_limit(input logic [sht_pkg::CFG_W-1:0] lim);
        cfg.valid = 1'b1;
        cfg.data = lim;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    // Waits until every predicted result has come back, then lets the block settle.
    task automatic drain();
        int guard;
        guard = 0;
        while (awaited != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (50) @(negedge clk);
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(255, 1));
    endfunction

    // One random operation. Most use well-formed pool names so the table fills and
    // probes run long; a few use special names or throwaway names.
    task automatic random_op();
        logic [1:0] fn;
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 45)
            fn = sht_pkg::FN_SET;
        else if (pick < 75)
            fn = sht_pkg::FN_LOOKUP;
        else if (pick < 95)
            fn = sht_pkg::FN_DELETE;
        else
            fn = sht_pkg::FN_SPARE;
        pick = $urandom_range(99);
        if (pick < 88)
            n = $urandom_range(POOL - 1, 8);
        else if (pick < 94)
            n = $urandom_range(7, 0);
        else
        begin
            n = 7;
            pool_len[7] = $urandom_range(40, 1);
            for (int k = 0; k < 40; k++)
                pool_bytes[7][k] = any_byte();
        end
        send_name(n, fn, {$urandom, $urandom}, 1'($urandom));
    endtask

    initial
    begin
        int limits [6];
        req.valid = 1'b0;
        req.func = sht_pkg::FN_SET;
        req.name_byte = 8'h41;
        req.last_byte = 1'b0;
        req.value_in = '0;
        req.const_in = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = sht_pkg::MAX_ENTRIES_RESET;

        // Special names: a single lowercase letter, a single all-ones byte, the longest
        // good name, a name one byte too long, a tombstone-marker name and a name
        // holding a zero byte.
        pool_len[0] = 1;
        pool_bytes[0][0] = 8'h61;
        pool_len[1] = 1;
        pool_bytes[1][0] = 8'hFF;
        pool_len[2] = 31;
        pool_len[3] = 32;
        for (int k = 0; k < 40; k++)
        begin
            pool_bytes[2][k] = any_byte();
            pool_bytes[3][k] = any_byte();
        end
        pool_len[4] = 3;
        pool_bytes[4][0] = sht_pkg::TOMB_BYTE;
        pool_bytes[4][1] = 8'h01;
        pool_bytes[4][2] = 8'h80;
        pool_len[5] = 3;
        pool_bytes[5][0] = 8'h62;
        pool_bytes[5][1] = 8'h00;
        pool_bytes[5][2] = 8'h63;
        pool_len[6] = 2;
        pool_bytes[6][0] = 8'h01;
        pool_bytes[6][1] = 8'h7F;
        pool_len[7] = 1;
        pool_bytes[7][0] = 8'h55;
        for (int n = 8; n < POOL; n++)
        begin
            pool_len[n] = ($urandom_range(99) < 90) ? $urandom_range(6, 1)
                                                    : $urandom_range(31, 7);
            for (int k = 0; k < 40; k++)
                pool_bytes[n][k] = any_byte();
            if (pool_bytes[n][0] == sht_pkg::TOMB_BYTE)
                pool_bytes[n][0] = 8'h41;
        end

        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Directed part with the reset load limit and no idling.
        send_name(0, sht_pkg::FN_LOOKUP, '0, 1'b0);           // lookup in an empty table
        send_name(0, sht_pkg::FN_DELETE, '0, 1'b0);           // delete in an empty table
        send_name(0, sht_pkg::FN_SET, '1, 1'b1);
        send_name(0, sht_pkg::FN_SET, '0, 1'b0);              // update of an existing name
        send_name(0, sht_pkg::FN_LOOKUP, '0, 1'b0);
        send_name(1, sht_pkg::FN_SET, 64'h8000_0000_0000_0001, 1'b1);
        send_name(1, sht_pkg::FN_SPARE, '0, 1'b0);            // unused func acts as lookup
        send_name(2, sht_pkg::FN_SET, '1, 1'b0);
        send_name(2, sht_pkg::FN_LOOKUP, '0, 1'b0);
        send_name(3, sht_pkg::FN_SET, '1, 1'b1);              // one byte too long
        send_name(4, sht_pkg::FN_SET, '1, 1'b1);              // tombstone-marker first byte
        send_name(5, sht_pkg::FN_SET, '1, 1'b1);              // zero byte inside
        send_name(6, sht_pkg::FN_SET, 64'h0123_4567_89AB_CDEF, 1'b0);
        send_name(0, sht_pkg::FN_DELETE, '0, 1'b0);
        send_name(0, sht_pkg::FN_DELETE, '0, 1'b0);           // delete of a deleted name
        send_name(0, sht_pkg::FN_LOOKUP, '0, 1'b0);
        send_name(0, sht_pkg::FN_SET, 64'h5A5A, 1'b1);        // reuses the tombstone
        drain();

        // Random phases over several load limits, extremes included. The idling
        // pattern repeats every three phases: receiver-heavy, sender-heavy, none.
        limits = '{63, 1, 20, 63, 5, 48};
        for (int p = 0; p < 6; p++)
        begin
            write_limit(limits[p][sht_pkg::CFG_W-1:0]);
            case (p % 3)
                0:
                begin
                    send_gap = 37;
                    recv_gap = 74;
                end
                1:
                begin
                    send_gap = 74;
                    recv_gap = 37;
                end
                default:
                begin
                    send_gap = 0;
                    recv_gap = 0;
                end
            endcase
            if (p == 2)
                hold_request = 400;
            for (int i = 0; i < 30; i++)
                random_op();
            drain();
        end

        if (fail_count == 0 && awaited == 0)
            $display("string_key_hash_table regression: pass");
        else
            $display("string_key_hash_table regression: fail");
        $finish;
    end

    initial
    begin
        #50000000;
        $display("string_key_hash_table regression: fail");
        $finish;
    end

endmodule
